### rtl/ddf_pkg.sv
`default_nettype none
package ddf_pkg;

	localparam int MAX_DIGITS = 10;
	localparam int NUM_W      = 32;
	localparam int BITCNT_W   = $clog2(NUM_W);
	localparam int CNT_W      = 4;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 3;
	localparam int SIZE_W     = 5;
	localparam int CODE_W     = 6;

	localparam logic [CODE_W-1:0] CODE_SPACE = 6'h20;
	localparam logic [CODE_W-1:0] CODE_ZERO  = 6'h30;

	typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [SIZE_W-1:0] size;
	} emit_cmd_t;

endpackage
`default_nettype wire

### rtl/ddf_bcd_conv.sv
`default_nettype none
module ddf_bcd_conv
	import ddf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] number,
	output logic                  done,
	output bcd_t                  bcd
);

	logic [NUM_W-1:0]    num_q;
	logic [BITCNT_W-1:0] bit_q;
	logic                busy_q;
	logic                done_q;
	bcd_t                bcd_q;
	bcd_t                adj;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == BITCNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= number;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[MAX_DIGITS-1][2:0], adj[MAX_DIGITS-2:0], num_q[NUM_W-1]};
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

### rtl/ddf_emit.sv
`default_nettype none
module ddf_emit
	import ddf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire emit_cmd_t         cmd,
	input  wire bcd_t              bcd,
	output logic                   idle,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [COL_W-1:0]       column,
	output logic [ROW_W-1:0]       row,
	output logic [CODE_W-1:0]      char_code,
	output logic [SIZE_W-1:0]      glyph_size,
	output logic                   last
);

	logic [CNT_W-1:0]  idx_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] size_q;
	logic              shown_q;
	logic              busy_q;
	logic              valid_q;
	logic [3:0]        digit;
	logic              is_last;
	logic              advance;

	assign digit   = bcd[idx_q];
	assign is_last = (idx_q == '0);
	assign advance = busy_q && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end else if (advance && is_last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			idx_q   <= cmd.count - 1'b1;
			col_q   <= cmd.column;
			row_q   <= cmd.row;
			size_q  <= cmd.size;
			shown_q <= 1'b0;
		end else if (advance) begin
			column     <= col_q;
			row        <= row_q;
			glyph_size <= size_q;
			last       <= is_last;
			if (!shown_q && !is_last && digit == 4'd0) begin
				char_code <= CODE_SPACE;
			end else begin
				char_code <= CODE_ZERO + {2'b00, digit};
				shown_q   <= 1'b1;
			end
			col_q <= col_q + COL_W'(size_q[SIZE_W-1:1]);
			idx_q <= idx_q - 1'b1;
		end
	end

	assign out_valid = valid_q;
	assign idle      = !busy_q && !valid_q;

endmodule
`default_nettype wire

### rtl/decimal_digit_display_formatter.sv
// After an input transfer the first placement is offered once the bit-serial
// binary to BCD conversion (one bit of the number per cycle) has finished
// and the handover into the emitter is done.
// Placements then follow at one per cycle while the output is taken.
// in_ready is high only in idle, after the last placement has transferred and
// the emitter has gone idle (for a zero count, once the conversion ends).
// Reset clears all control state at once; no clearing pass.
`default_nettype none
module decimal_digit_display_formatter
	import ddf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [NUM_W-1:0]  number,
	input  wire logic [CNT_W-1:0]  digit_count,
	input  wire logic [COL_W-1:0]  start_column,
	input  wire logic [ROW_W-1:0]  page_row,
	input  wire logic [SIZE_W-1:0] font_height,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [COL_W-1:0]       column,
	output logic [ROW_W-1:0]       row,
	output logic [CODE_W-1:0]      char_code,
	output logic [SIZE_W-1:0]      glyph_size,
	output logic                   last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t    state_q;
	emit_cmd_t cmd_q;
	logic      emit_start_q;
	logic      conv_done;
	logic      emit_idle;
	bcd_t      bcd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			emit_start_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						if (cmd_q.count == '0) begin
							state_q <= ST_IDLE;
						end else begin
							emit_start_q <= 1'b1;
							state_q      <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					emit_start_q <= 1'b0;
					if (!emit_start_q && emit_idle) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.count  <= (digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
			                                                   : digit_count;
			cmd_q.column <= start_column;
			cmd_q.row    <= page_row;
			cmd_q.size   <= font_height;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	ddf_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && in_ready),
		.number (number),
		.done   (conv_done),
		.bcd    (bcd)
	);

	ddf_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (emit_start_q),
		.cmd        (cmd_q),
		.bcd        (bcd),
		.idle       (emit_idle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.column     (column),
		.row        (row),
		.char_code  (char_code),
		.glyph_size (glyph_size),
		.last       (last)
	);

endmodule
`default_nettype wire

### verif/decimal_digit_display_formatter_tb.sv
module decimal_digit_display_formatter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ddf_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int LONG_HOLD       = 300;
	localparam int ITEMS_PER_PHASE = 103;
	localparam int SETTLE_CYCLES   = 60;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		logic [NUM_W-1:0]  number;
		logic [CNT_W-1:0]  count;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [SIZE_W-1:0] size;
	} number_item_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [CODE_W-1:0] code;
		logic [SIZE_W-1:0] size;
		logic              last;
	} placement_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [NUM_W-1:0]  number       = '0;
	logic [CNT_W-1:0]  digit_count  = '0;
	logic [COL_W-1:0]  start_column = '0;
	logic [ROW_W-1:0]  page_row     = '0;
	logic [SIZE_W-1:0] font_height  = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [COL_W-1:0]  column;
	logic [ROW_W-1:0]  row;
	logic [CODE_W-1:0] char_code;
	logic [SIZE_W-1:0] glyph_size;
	logic              last;

	number_item_t pending_numbers[$];
	placement_t   expected_placements[$];
	number_item_t offered;

	int          sender_idle_pct   = 0;
	int          receiver_stall_pct = 0;
	bit          hold_request      = 1'b0;
	int unsigned hold_cycles_left  = 0;
	int          mismatch_count    = 0;
	int          cycle_count       = 0;

	decimal_digit_display_formatter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.digit_count  (digit_count),
		.start_column (start_column),
		.page_row     (page_row),
		.font_height  (font_height),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column       (column),
		.row          (row),
		.char_code    (char_code),
		.glyph_size   (glyph_size),
		.last         (last)
	);

	always #2 clk = ~clk;

	function automatic void queue_placements(input number_item_t it);
		int unsigned digits;
		int unsigned pos;
		int unsigned k;
		int unsigned scale;
		int unsigned digit;
		int unsigned col;
		bit          shown;
		placement_t  p;
		digits = (it.count > MAX_DIGITS) ? MAX_DIGITS : it.count;
		shown = 1'b0;
		for (pos = 0; pos < digits; pos++) begin
			scale = 1;
			for (k = 0; k < digits - 1 - pos; k++)
				scale = scale * 10;
			digit = (it.number / scale) % 10;
			col = (it.column + (it.size / 2) * pos) % 256;
			p.column = COL_W'(col);
			p.row = it.row;
			p.size = it.size;
			p.last = (pos + 1 == digits);
			if (!shown && !p.last && digit == 0) begin
				p.code = CODE_SPACE;
			end else begin
				shown = 1'b1;
				p.code = CODE_ZERO + CODE_W'(digit);
			end
			expected_placements.push_back(p);
		end
	endfunction

	task automatic push_number(input logic [NUM_W-1:0] num, input int cnt, input int col,
			input int pg, input int sz);
		number_item_t it;
		it.number = num;
		it.count = CNT_W'(cnt);
		it.column = COL_W'(col);
		it.row = ROW_W'(pg);
		it.size = SIZE_W'(sz);
		pending_numbers.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_numbers.size() != 0 || in_valid || expected_placements.size() != 0)
			@(negedge clk);
	endtask

	// sender: predict on each input transfer, then offer the next pending number
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			number <= '0;
			digit_count <= '0;
			start_column <= '0;
			page_row <= '0;
			font_height <= '0;
		end else begin
			if (in_valid && in_ready)
				queue_placements(offered);
			if (!in_valid || in_ready) begin
				if (pending_numbers.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					offered = pending_numbers.pop_front();
					in_valid <= 1'b1;
					number <= offered.number;
					digit_count <= offered.count;
					start_column <= offered.column;
					page_row <= offered.row;
					font_height <= offered.size;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles_left <= 0;
		end else if (hold_cycles_left != 0) begin
			hold_cycles_left <= hold_cycles_left - 1;
		end else if (hold_request) begin
			hold_cycles_left <= LONG_HOLD;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		placement_t got;
		placement_t exp;
		if (arst_n && out_valid && out_ready) begin
			got = {column, row, char_code, glyph_size, last};
			if (expected_placements.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected placement: col=%0d row=%0d code=%h size=%0d last=%0b",
						got.column, got.row, got.code, got.size, got.last);
			end else begin
				exp = expected_placements.pop_front();
				if (got.column !== exp.column || got.row !== exp.row || got.code !== exp.code
						|| got.size !== exp.size || got.last !== exp.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("placement mismatch: exp col=%0d row=%0d code=%h size=%0d last=%0b, got col=%0d row=%0d code=%h size=%0d last=%0b",
							exp.column, exp.row, exp.code, exp.size, exp.last,
							got.column, got.row, got.code, got.size, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int          phase;
		int          n;
		int          cnt;
		int unsigned scale;
		logic [NUM_W-1:0] num;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_number(32'd0, 10, 0, 0, 0);
		push_number(32'hFFFF_FFFF, 10, 255, 7, 31);
		push_number(32'd123, 0, 10, 3, 8);
		push_number(32'hFFFF_FFFF, 15, 0, 5, 16);
		push_number(32'd1234567890, 11, 200, 2, 12);
		push_number(32'd0, 1, 7, 1, 6);
		push_number(32'd7, 1, 0, 0, 1);
		push_number(32'd1000000000, 10, 250, 6, 30);
		push_number(32'd100, 5, 0, 4, 10);
		push_number(32'd987654321, 3, 128, 2, 14);
		push_number(32'd5000, 3, 64, 3, 9);
		push_number(32'd1234567890, 10, 40, 0, 0);
		push_number(32'd9, 4, 255, 7, 31);
		push_number(32'h8000_0000, 10, 1, 1, 3);
		push_number(32'd42, 9, 100, 4, 20);
		push_number(32'd1, 2, 16, 5, 4);
		push_number(32'd10, 2, 8, 6, 18);
		push_number(32'd0, 12, 170, 2, 21);
		wait_drained();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
				default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
			endcase
			// hold the output back while numbers keep being offered
			if (phase == 0 || phase == 3) begin
				hold_request = 1'b1;
				@(negedge clk);
				hold_request = 1'b0;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				cnt = ($urandom_range(9) == 0) ? $urandom_range(15, 11) : $urandom_range(10);
				case ($urandom_range(3))
					0: num = $urandom();
					1: begin
						scale = 1;
						repeat ($urandom_range(9)) scale = scale * 10;
						num = $urandom() % scale;
					end
					2: begin
						scale = 1;
						repeat ($urandom_range(9)) scale = scale * 10;
						num = scale * $urandom_range(9);
					end
					default: num = $urandom_range(999);
				endcase
				push_number(num, cnt, $urandom_range(255), $urandom_range(7), $urandom_range(31));
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### decimal_digit_display_formatter.f
rtl/ddf_pkg.sv
rtl/ddf_bcd_conv.sv
rtl/ddf_emit.sv
rtl/decimal_digit_display_formatter.sv
verif/decimal_digit_display_formatter_tb.sv
